// File: rtl/core/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define DLEX_ASSERT(name, ck, rn, prop) \
  name: assert property (@(posedge ck) disable iff (!rn) prop) \
    else $error("assertion failed");
`define DLEX_NEVER(name, ck, rn, cond) \
  name: assert property (@(posedge ck) disable iff (!rn) !(cond)) \
    else $error("forbidden condition seen");
`else
`define DLEX_ASSERT(name, ck, rn, prop)
`define DLEX_NEVER(name, ck, rn, cond)
`endif

`endif

// File: rtl/core/dlex_pkg.sv
package dlex_pkg;

  localparam logic [3:0] K_VOID   = 4'd0;
  localparam logic [3:0] K_CONST  = 4'd1;
  localparam logic [3:0] K_REF    = 4'd2;
  localparam logic [3:0] K_SEMI   = 4'd3;
  localparam logic [3:0] K_OPEN   = 4'd4;
  localparam logic [3:0] K_CLOSE  = 4'd5;
  localparam logic [3:0] K_STAR   = 4'd6;
  localparam logic [3:0] K_ASSIGN = 4'd7;
  localparam logic [3:0] K_COMMA  = 4'd8;
  localparam logic [3:0] K_IDENT  = 4'd9;
  localparam logic [3:0] K_NUMBER = 4'd10;
  localparam logic [3:0] K_BODY   = 4'd11;
  localparam logic [3:0] K_ERROR  = 4'd12;

  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_USCORE = 8'h5F;
  localparam logic [7:0] CH_COLON  = 8'h3A;

  localparam int QDEPTH = 4;
  localparam int QAW    = 2;
  localparam int QCW    = 3;

  localparam logic [3:0] KW_LEN [4] = '{4'd4, 4'd5, 4'd6, 4'd9};

  localparam logic [7:0] KW_CH [4][16] = '{
    '{"v", "o", "i", "d", 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"c", "o", "n", "s", "t", 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"i", "n", "l", "i", "n", "e", 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"I", "M", "G", "U", "I", "_", "A", "P",
      "I", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
  };

  typedef enum logic [7:0] {
    M_IDLE    = 8'b0000_0001,
    M_SLASH   = 8'b0000_0010,
    M_COMMENT = 8'b0000_0100,
    M_BODY    = 8'b0000_1000,
    M_INT     = 8'b0001_0000,
    M_DOT     = 8'b0010_0000,
    M_FRAC    = 8'b0100_0000,
    M_IDENT   = 8'b1000_0000
  } mode_t;

  typedef struct packed {
    logic [3:0]  kind;
    logic [15:0] start;
    logic [15:0] len;
    logic        last;
  } tok_t;

  typedef struct packed {
    logic [1:0] n;
    tok_t       a;
    tok_t       b;
  } push_t;

  typedef struct packed {
    logic             room;
    logic [QCW-1:0]   count;
  } q_stat_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic [3:0] kw_feed(input logic [3:0] flags, input logic [3:0] cnt,
                                         input logic [7:0] c);
    logic [3:0] f;
    f = flags;
    for (int k = 0; k < 4; k++) begin
      if (cnt >= KW_LEN[k] || KW_CH[k][cnt] != c) begin
        f[k] = 1'b0;
      end
    end
    return f;
  endfunction

  function automatic tok_t mk_tok(input logic [3:0] kind, input logic [15:0] start,
                                  input logic [15:0] len);
    tok_t t;
    t.kind  = kind;
    t.start = start;
    t.len   = len;
    t.last  = 1'b0;
    return t;
  endfunction

endpackage

// File: rtl/core/dlex_front.sv
module dlex_front #(
  parameter int unsigned     MAX_NEST = 255,
  parameter longint unsigned MAX_TEXT = 65535
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            fire,
  input  logic [7:0]      ch,
  input  logic            eot,
  output dlex_pkg::push_t push
);
  import dlex_pkg::*;

  localparam int NW = $clog2(MAX_NEST + 1);
  localparam int PW = $clog2(MAX_TEXT + 1);
  localparam int XW = (PW + 1 > 17) ? PW + 1 : 17;

  mode_t          mode_r, mode_nxt;
  logic [NW-1:0]  nest_r, nest_nxt;
  logic [PW-1:0]  pos_r, pos_nxt;
  logic [PW-1:0]  beg_r, beg_nxt;
  logic [3:0]     kwf_r, kwf_nxt;
  logic [3:0]     icnt_r, icnt_nxt;

  function automatic logic [15:0] sat16(input logic [XW-1:0] v);
    return (v > XW'(17'h0FFFF)) ? 16'hFFFF : v[15:0];
  endfunction

  logic [XW-1:0] len0, len1;
  logic [15:0]   beg_s, pos_s, len0_s, len1_s;

  logic          sc_emit, sc_begin, sc_body, sc_ident;
  logic [3:0]    sc_kind;
  mode_t         sc_mode;

  logic          if_emit;
  logic [3:0]    if_kind;

  logic          t0v, t1v, do_start;
  tok_t          t0, t1;

  assign len0   = XW'(pos_r) - XW'(beg_r);
  assign len1   = len0 + XW'(1);
  assign beg_s  = sat16(XW'(beg_r));
  assign pos_s  = sat16(XW'(pos_r));
  assign len0_s = sat16(len0);
  assign len1_s = sat16(len1);

  always_comb begin
    sc_emit  = 1'b0;
    sc_kind  = K_ERROR;
    sc_mode  = M_IDLE;
    sc_begin = 1'b0;
    sc_body  = 1'b0;
    sc_ident = 1'b0;
    priority if (is_space(ch)) begin
    end else if (ch == CH_SEMI) begin
      sc_emit = 1'b1; sc_kind = K_SEMI;
    end else if (ch == CH_AMP) begin
      sc_emit = 1'b1; sc_kind = K_REF;
    end else if (ch == CH_STAR) begin
      sc_emit = 1'b1; sc_kind = K_STAR;
    end else if (ch == CH_LPAREN) begin
      sc_emit = 1'b1; sc_kind = K_OPEN;
    end else if (ch == CH_RPAREN) begin
      sc_emit = 1'b1; sc_kind = K_CLOSE;
    end else if (ch == CH_EQ) begin
      sc_emit = 1'b1; sc_kind = K_ASSIGN;
    end else if (ch == CH_COMMA) begin
      sc_emit = 1'b1; sc_kind = K_COMMA;
    end else if (ch == CH_SLASH) begin
      sc_mode = M_SLASH; sc_begin = 1'b1;
    end else if (ch == CH_LBRACE) begin
      sc_mode = M_BODY; sc_begin = 1'b1; sc_body = 1'b1;
    end else if (is_digit(ch)) begin
      sc_mode = M_INT; sc_begin = 1'b1;
    end else if (is_alpha(ch)) begin
      sc_mode = M_IDENT; sc_begin = 1'b1; sc_ident = 1'b1;
    end else begin
      sc_emit = 1'b1; sc_kind = K_ERROR;
    end
  end

  always_comb begin
    if_emit = 1'b1;
    if_kind = K_IDENT;
    priority if (kwf_r[0] && icnt_r == KW_LEN[0]) begin
      if_kind = K_VOID;
    end else if (kwf_r[1] && icnt_r == KW_LEN[1]) begin
      if_kind = K_CONST;
    end else if ((kwf_r[2] && icnt_r == KW_LEN[2]) || (kwf_r[3] && icnt_r == KW_LEN[3])) begin
      if_emit = 1'b0;
    end else begin
    end
  end

  always_comb begin
    mode_nxt = mode_r;
    nest_nxt = nest_r;
    pos_nxt  = pos_r;
    beg_nxt  = beg_r;
    kwf_nxt  = kwf_r;
    icnt_nxt = icnt_r;
    t0v      = 1'b0;
    t0       = mk_tok(K_ERROR, beg_s, len0_s);
    do_start = 1'b0;
    if (eot) begin
      unique case (mode_r)
        M_IDENT: begin
          t0v = if_emit; t0 = mk_tok(if_kind, beg_s, len0_s);
        end
        M_INT, M_DOT, M_FRAC: begin
          t0v = 1'b1; t0 = mk_tok(K_NUMBER, beg_s, len0_s);
        end
        M_SLASH: begin
          t0v = 1'b1; t0 = mk_tok(K_ERROR, beg_s, 16'd1);
        end
        M_BODY: begin
          t0v = 1'b1; t0 = mk_tok(K_ERROR, beg_s, len0_s);
        end
        default: begin
        end
      endcase
      mode_nxt = M_IDLE;
      nest_nxt = '0;
      pos_nxt  = '0;
      beg_nxt  = '0;
      kwf_nxt  = 4'hF;
      icnt_nxt = 4'd0;
    end else begin
      unique case (mode_r)
        M_SLASH: begin
          if (ch == CH_SLASH) begin
            mode_nxt = M_COMMENT;
          end else begin
            t0v = 1'b1; t0 = mk_tok(K_ERROR, beg_s, 16'd1); do_start = 1'b1;
          end
        end
        M_COMMENT: begin
          if (ch == CH_NL) mode_nxt = M_IDLE;
        end
        M_BODY: begin
          if (ch == CH_LBRACE) begin
            if (nest_r >= NW'(MAX_NEST)) begin
              t0v = 1'b1; t0 = mk_tok(K_ERROR, beg_s, len1_s);
              mode_nxt = M_IDLE;
              nest_nxt = '0;
            end else begin
              nest_nxt = nest_r + NW'(1);
            end
          end else if (ch == CH_RBRACE) begin
            nest_nxt = nest_r - NW'(1);
            if (nest_r == NW'(1)) begin
              t0v = 1'b1; t0 = mk_tok(K_BODY, beg_s, len1_s);
              mode_nxt = M_IDLE;
            end
          end
        end
        M_INT: begin
          if (ch == CH_DOT) begin
            mode_nxt = M_DOT;
          end else if (!is_digit(ch)) begin
            t0v = 1'b1; t0 = mk_tok(K_NUMBER, beg_s, len0_s); do_start = 1'b1;
          end
        end
        M_DOT: begin
          if (is_digit(ch)) begin
            mode_nxt = M_FRAC;
          end else begin
            t0v = 1'b1; t0 = mk_tok(K_NUMBER, beg_s, len0_s); do_start = 1'b1;
          end
        end
        M_FRAC: begin
          if (ch == CH_F) begin
            t0v = 1'b1; t0 = mk_tok(K_NUMBER, beg_s, len1_s);
            mode_nxt = M_IDLE;
          end else if (!is_digit(ch)) begin
            t0v = 1'b1; t0 = mk_tok(K_NUMBER, beg_s, len0_s); do_start = 1'b1;
          end
        end
        M_IDENT: begin
          if (is_alpha(ch) || is_digit(ch) || ch == CH_USCORE || ch == CH_COLON) begin
            kwf_nxt = kw_feed(kwf_r, icnt_r, ch);
            if (icnt_r != 4'd15) icnt_nxt = icnt_r + 4'd1;
          end else begin
            t0v = if_emit; t0 = mk_tok(if_kind, beg_s, len0_s); do_start = 1'b1;
          end
        end
        default: begin
          do_start = 1'b1;
        end
      endcase
      if (do_start) begin
        mode_nxt = sc_mode;
        if (sc_begin) beg_nxt = pos_r;
        if (sc_body) nest_nxt = NW'(1);
        if (sc_ident) begin
          kwf_nxt  = kw_feed(4'hF, 4'd0, ch);
          icnt_nxt = 4'd1;
        end
      end
      if (pos_r < PW'(MAX_TEXT)) pos_nxt = pos_r + PW'(1);
    end
  end

  assign t1v = do_start && !eot && sc_emit;

  always_comb begin
    t1      = mk_tok(sc_kind, pos_s, 16'd1);
    t1.last = 1'b1;
    push.b  = t1;
    push.a  = t0v ? t0 : t1;
    push.a.last = !(t0v && t1v);
    push.n  = fire ? ({1'b0, t0v} + {1'b0, t1v}) : 2'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE;
      nest_r <= '0;
      pos_r  <= '0;
      beg_r  <= '0;
      kwf_r  <= 4'hF;
      icnt_r <= 4'd0;
    end else if (fire) begin
      mode_r <= mode_nxt;
      nest_r <= nest_nxt;
      pos_r  <= pos_nxt;
      beg_r  <= beg_nxt;
      kwf_r  <= kwf_nxt;
      icnt_r <= icnt_nxt;
    end
  end

endmodule

// File: rtl/core/dlex_queue.sv
module dlex_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  dlex_pkg::push_t   push,
  input  logic              pop_rdy,
  output logic              head_vld,
  output dlex_pkg::tok_t    head,
  output dlex_pkg::q_stat_t stat
);
  import dlex_pkg::*;

  tok_t           mem_r [QDEPTH];
  logic [QAW-1:0] wr_r, wr_nxt;
  logic [QAW-1:0] rd_r, rd_nxt;
  logic [QCW-1:0] cnt_r, cnt_nxt;
  logic           pop;

  assign head_vld   = cnt_r != '0;
  assign head       = mem_r[rd_r];
  assign pop        = head_vld && pop_rdy;
  assign stat.count = cnt_r;
  assign stat.room  = cnt_r <= QCW'(QDEPTH - 2);

  assign wr_nxt  = wr_r + QAW'(push.n);
  assign rd_nxt  = rd_r + QAW'(pop);
  assign cnt_nxt = cnt_r + QCW'(push.n) - QCW'(pop);

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) mem_r[wr_r] <= push.a;
    if (push.n == 2'd2) mem_r[wr_r + QAW'(1)] <= push.b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// File: rtl/core/declaration_lexer_top.sv
// Declaration lexer: turns C-like declaration text into tokens.
// Input stream: one character word per accepted beat. in_tdata[7:0] is the
// character; in_tlast high marks end of text, which flushes the pending token
// and restarts offsets at 0 (the character of that word is ignored).
// Output stream: one token word per beat; out_tdata holds start offset [15:0]
// and length [31:16], out_tuser carries the token kind; out_tlast marks the
// final token caused by one input word.
// Throughput: one character per cycle while in_tready is high. The lexer
// state is updated at the clock edge that accepts a character; that edge
// also writes its tokens into a four-entry queue, which drives out_tvalid.
// A character may yield two tokens; they enter the queue together, in order.
// in_tready drops while fewer than two queue slots are free, so a stalled
// receiver backs up the input, holding at most four tokens; no token is lost.
// Reset (rst_n low, synchronous) empties the queue and returns the lexer to
// idle at offset 0.
`include "assert_macros.svh"

module declaration_lexer_top #(
  parameter int unsigned     MAX_NEST = 255,
  parameter longint unsigned MAX_TEXT = 65535
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // ch
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // start_offset, token_length
  output logic [3:0]  out_tuser,  // token_kind
  output logic        out_tlast
);
  import dlex_pkg::*;

  push_t   push;
  tok_t    head;
  q_stat_t stat;
  logic    fire;

  assign in_tready = stat.room;
  assign fire      = in_tvalid && in_tready;

  dlex_front #(
    .MAX_NEST (MAX_NEST),
    .MAX_TEXT (MAX_TEXT)
  ) u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .ch    (in_tdata),
    .eot   (in_tlast),
    .push  (push)
  );

  dlex_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .pop_rdy  (out_tready),
    .head_vld (out_tvalid),
    .head     (head),
    .stat     (stat)
  );

  assign out_tdata = {head.len, head.start};
  assign out_tuser = head.kind;
  assign out_tlast = head.last;

  `DLEX_NEVER(a_q_over, clk, rst_n, stat.count > QCW'(QDEPTH))
  `DLEX_ASSERT(a_push_fire, clk, rst_n, (push.n != 2'd0) |-> fire)
  `DLEX_ASSERT(a_pair_last, clk, rst_n, (push.n == 2'd2) |-> (!push.a.last && push.b.last))
  `DLEX_ASSERT(a_ready_room, clk, rst_n, in_tready |-> (stat.count <= QCW'(QDEPTH - 2)))

endmodule

// File: sim/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import dlex_pkg::*;

  localparam int unsigned NEST_LIMIT = 255;
  localparam int unsigned TEXT_LIMIT = 65535;
  localparam int unsigned RANDOM_ITEMS = 950;
  localparam int unsigned MAX_REPORTS = 10;
  localparam int unsigned HOLD_CYCLES = 300;

  localparam int unsigned KW_VOID = 0;
  localparam int unsigned KW_CONST = 1;
  localparam int unsigned KW_INLINE = 2;
  localparam int unsigned KW_API = 3;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;   // ch
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;          // start_offset, token_length
  logic [3:0]  out_tuser;          // token_kind
  logic        out_tlast;

  declaration_lexer_top #(
    .MAX_NEST(NEST_LIMIT),
    .MAX_TEXT(TEXT_LIMIT)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tlast(in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .out_tlast(out_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Lexer state mirrored in the testbench.
  mode_t       lx_mode = M_IDLE;
  int unsigned depth = 0;
  int unsigned cursor = 0;
  int unsigned tok_begin = 0;
  logic [3:0]  kw_alive = 4'hF;
  int unsigned ident_len = 0;
  int unsigned step_count = 0;

  tok_t        expected_tokens[$];
  logic [7:0]  text_buf[$];

  bit          tx_gaps_on = 1'b1;
  bit          rx_gaps_on = 1'b1;
  int unsigned hold_request = 0;
  int unsigned stall_left = 0;
  int unsigned sent_items = 0;
  int unsigned mismatch_count = 0;
  tok_t        want;

  function automatic string keyword(int unsigned k);
    case (k)
      KW_VOID:   return "void";
      KW_CONST:  return "const";
      KW_INLINE: return "inline";
      default:   return {"IMG", "UI_API"};
    endcase
  endfunction

  function automatic bit is_blank(logic [7:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic bit is_num(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_letter(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic void lexer_reset();
    lx_mode = M_IDLE;
    depth = 0;
    cursor = 0;
    tok_begin = 0;
    kw_alive = 4'hF;
    ident_len = 0;
  endfunction

  function automatic void add_token(logic [3:0] kind, int unsigned from, int unsigned span);
    tok_t t;
    t.kind  = kind;
    t.start = (from > 32'hFFFF) ? 16'hFFFF : from[15:0];
    t.len   = (span > 32'hFFFF) ? 16'hFFFF : span[15:0];
    t.last  = 1'b0;
    expected_tokens.insert(expected_tokens.size(), t);
    step_count++;
  endfunction

  function automatic void kw_step(logic [7:0] c);
    string w;
    for (int k = 0; k < 4; k++) begin
      w = keyword(k);
      if (ident_len >= w.len() || w[ident_len] != c) begin
        kw_alive[k] = 1'b0;
      end
    end
    if (ident_len < 15) begin
      ident_len++;
    end
  endfunction

  function automatic void ident_close(int unsigned span);
    string w;
    for (int k = 0; k < 4; k++) begin
      w = keyword(k);
      if (kw_alive[k] && ident_len == w.len()) begin
        if (k == KW_VOID) begin
          add_token(K_VOID, tok_begin, span);
        end else if (k == KW_CONST) begin
          add_token(K_CONST, tok_begin, span);
        end
        return;
      end
    end
    add_token(K_IDENT, tok_begin, span);
  endfunction

  function automatic void open_token(logic [7:0] c, int unsigned pos);
    lx_mode = M_IDLE;
    if (is_blank(c)) begin
      return;
    end
    case (c)
      CH_SEMI:   add_token(K_SEMI, pos, 1);
      CH_AMP:    add_token(K_REF, pos, 1);
      CH_STAR:   add_token(K_STAR, pos, 1);
      CH_LPAREN: add_token(K_OPEN, pos, 1);
      CH_RPAREN: add_token(K_CLOSE, pos, 1);
      CH_EQ:     add_token(K_ASSIGN, pos, 1);
      CH_COMMA:  add_token(K_COMMA, pos, 1);
      CH_SLASH: begin
        lx_mode = M_SLASH;
        tok_begin = pos;
      end
      CH_LBRACE: begin
        lx_mode = M_BODY;
        depth = 1;
        tok_begin = pos;
      end
      default: begin
        if (is_num(c)) begin
          lx_mode = M_INT;
          tok_begin = pos;
        end else if (is_letter(c)) begin
          lx_mode = M_IDENT;
          tok_begin = pos;
          kw_alive = 4'hF;
          ident_len = 0;
          kw_step(c);
        end else begin
          add_token(K_ERROR, pos, 1);
        end
      end
    endcase
  endfunction

  function automatic void lex_step(logic [7:0] c, logic eot);
    int unsigned pos;
    tok_t t;
    pos = cursor;
    step_count = 0;
    if (eot) begin
      case (lx_mode)
        M_IDENT: ident_close(pos - tok_begin);
        M_INT, M_DOT, M_FRAC: add_token(K_NUMBER, tok_begin, pos - tok_begin);
        M_SLASH: add_token(K_ERROR, tok_begin, 1);
        M_BODY: add_token(K_ERROR, tok_begin, pos - tok_begin);
        default: ;
      endcase
      lexer_reset();
    end else begin
      case (lx_mode)
        M_SLASH: begin
          if (c == CH_SLASH) begin
            lx_mode = M_COMMENT;
          end else begin
            add_token(K_ERROR, tok_begin, 1);
            open_token(c, pos);
          end
        end
        M_COMMENT: begin
          if (c == CH_NL) begin
            lx_mode = M_IDLE;
          end
        end
        M_BODY: begin
          if (c == CH_LBRACE) begin
            if (depth >= NEST_LIMIT) begin
              add_token(K_ERROR, tok_begin, pos - tok_begin + 1);
              lx_mode = M_IDLE;
              depth = 0;
            end else begin
              depth++;
            end
          end else if (c == CH_RBRACE) begin
            depth--;
            if (depth == 0) begin
              add_token(K_BODY, tok_begin, pos - tok_begin + 1);
              lx_mode = M_IDLE;
            end
          end
        end
        M_INT: begin
          if (c == CH_DOT) begin
            lx_mode = M_DOT;
          end else if (!is_num(c)) begin
            add_token(K_NUMBER, tok_begin, pos - tok_begin);
            open_token(c, pos);
          end
        end
        M_DOT: begin
          if (is_num(c)) begin
            lx_mode = M_FRAC;
          end else begin
            add_token(K_NUMBER, tok_begin, pos - tok_begin);
            open_token(c, pos);
          end
        end
        M_FRAC: begin
          if (c == CH_F) begin
            add_token(K_NUMBER, tok_begin, pos - tok_begin + 1);
            lx_mode = M_IDLE;
          end else if (!is_num(c)) begin
            add_token(K_NUMBER, tok_begin, pos - tok_begin);
            open_token(c, pos);
          end
        end
        M_IDENT: begin
          if (is_letter(c) || is_num(c) || c == CH_USCORE || c == CH_COLON) begin
            kw_step(c);
          end else begin
            ident_close(pos - tok_begin);
            open_token(c, pos);
          end
        end
        default: open_token(c, pos);
      endcase
      if (cursor < TEXT_LIMIT) begin
        cursor++;
      end
    end
    if (step_count != 0) begin
      t = expected_tokens.pop_back();
      t.last = 1'b1;
      expected_tokens.insert(expected_tokens.size(), t);
    end
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_request != 0) begin
      stall_left = hold_request;
      hold_request = 0;
      out_tready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else begin
      if (rx_gaps_on) begin
        stall_left = pick_gap();
      end
      out_tready <= (stall_left == 0);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_tokens.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
          $display("unexpected token: kind %0d start %0d len %0d last %0b",
                   out_tuser, out_tdata[15:0], out_tdata[31:16], out_tlast);
        end
      end else begin
        want = expected_tokens.pop_front();
        if (out_tuser != want.kind || out_tdata[15:0] != want.start ||
            out_tdata[31:16] != want.len || out_tlast != want.last) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $write("token mismatch: expected kind %0d start %0d len %0d last %0b, ",
                   want.kind, want.start, want.len, want.last);
            $display("got kind %0d start %0d len %0d last %0b",
                     out_tuser, out_tdata[15:0], out_tdata[31:16], out_tlast);
          end
        end
      end
    end
  end

  task automatic send_word(logic [7:0] c, logic eot);
    int unsigned gap;
    gap = tx_gaps_on ? pick_gap() : 0;
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= c;
    in_tlast <= eot;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    lex_step(c, eot);
    sent_items++;
  endtask

  task automatic send_string(string s);
    for (int i = 0; i < s.len(); i++) begin
      send_word(s[i], 1'b0);
    end
  endtask

  task automatic end_text();
    send_word(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic wait_tokens_drained();
    in_tvalid <= 1'b0;
    while (expected_tokens.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [7:0] any_letter();
    int unsigned r;
    r = $urandom_range(0, 51);
    return 8'((r < 26) ? "a" + r : "A" + (r - 26));
  endfunction

  function automatic logic [7:0] ident_char();
    case ($urandom_range(0, 5))
      0: return 8'("0" + $urandom_range(0, 9));
      1: return CH_USCORE;
      2: return CH_COLON;
      default: return any_letter();
    endcase
  endfunction

  function automatic void put_char(logic [7:0] c);
    text_buf.insert(text_buf.size(), c);
  endfunction

  function automatic void put_str(string s);
    for (int i = 0; i < s.len(); i++) begin
      put_char(s[i]);
    end
  endfunction

  function automatic void put_blank();
    int unsigned r;
    r = $urandom_range(0, 6);
    put_char((r == 6) ? CH_SPACE : 8'(CH_TAB + (r % 5)));
  endfunction

  function automatic void put_ident();
    int unsigned n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 22) : $urandom_range(0, 6);
    put_char(any_letter());
    repeat (n) put_char(ident_char());
  endfunction

  function automatic void put_keyword();
    string w;
    int unsigned n;
    w = keyword($urandom_range(KW_VOID, KW_API));
    case ($urandom_range(0, 3))
      0: begin
        n = $urandom_range(1, w.len() - 1);
        for (int i = 0; i < n; i++) begin
          put_char(w[i]);
        end
      end
      1: begin
        put_str(w);
        repeat ($urandom_range(1, 3)) put_char(ident_char());
      end
      default: put_str(w);
    endcase
  endfunction

  function automatic void put_number();
    repeat ($urandom_range(1, 4)) put_char(8'("0" + $urandom_range(0, 9)));
    if ($urandom_range(0, 1) == 0) begin
      put_char(CH_DOT);
      repeat ($urandom_range(0, 3)) put_char(8'("0" + $urandom_range(0, 9)));
      if ($urandom_range(0, 1) == 0) begin
        put_char(CH_F);
      end
    end
  endfunction

  function automatic void put_punct();
    case ($urandom_range(0, 6))
      0: put_char(CH_SEMI);
      1: put_char(CH_AMP);
      2: put_char(CH_STAR);
      3: put_char(CH_LPAREN);
      4: put_char(CH_RPAREN);
      5: put_char(CH_EQ);
      default: put_char(CH_COMMA);
    endcase
  endfunction

  function automatic void put_comment();
    put_str("//");
    repeat ($urandom_range(0, 10)) put_char(8'($urandom_range(32, 126)));
    put_char(CH_NL);
  endfunction

  function automatic void put_body(int unsigned level);
    logic [7:0] c;
    put_char(CH_LBRACE);
    repeat ($urandom_range(0, 6)) begin
      if (level < 3 && $urandom_range(0, 3) == 0) begin
        put_body(level + 1);
      end else begin
        c = 8'($urandom_range(0, 255));
        while (c == CH_LBRACE || c == CH_RBRACE) c = 8'($urandom_range(0, 255));
        put_char(c);
      end
    end
    put_char(CH_RBRACE);
  endfunction

  function automatic void put_piece();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 4) begin
      put_ident();
    end else if (r < 6) begin
      put_keyword();
    end else if (r < 8) begin
      put_number();
    end else if (r < 11) begin
      put_punct();
    end else if (r < 14) begin
      put_blank();
    end else if (r == 14) begin
      put_comment();
    end else if (r == 15) begin
      put_body(0);
    end else if (r == 16) begin
      put_char(CH_SLASH);
    end else begin
      put_char(8'($urandom_range(0, 255)));
    end
  endfunction

  task automatic test_directed_tokens();
    send_string("const void*p=2.5f,(1.)&_;/q{}");
    send_word(8'h00, 1'b0);
    send_word(8'hFF, 1'b0);
    send_word(8'hFF, 1'b1);
    wait_tokens_drained();
  endtask

  task automatic test_text_end_flush();
    send_string("ab");
    end_text();
    send_string("12.");
    end_text();
    send_string("/");
    end_text();
    send_string("{{x}");
    end_text();
    send_string("//c");
    end_text();
    send_string("inline");
    end_text();
    end_text();
    wait_tokens_drained();
  endtask

  task automatic test_body_nesting();
    repeat (NEST_LIMIT) send_word(CH_LBRACE, 1'b0);
    repeat (NEST_LIMIT) send_word(CH_RBRACE, 1'b0);
    repeat (NEST_LIMIT + 1) send_word(CH_LBRACE, 1'b0);
    send_string("}a");
    end_text();
    wait_tokens_drained();
  endtask

  task automatic test_receiver_hold();
    tx_gaps_on = 1'b0;
    hold_request = HOLD_CYCLES;
    repeat (20) send_string("x,");
    send_string(";(*)");
    end_text();
    wait_tokens_drained();
    tx_gaps_on = 1'b1;
  endtask

  task automatic test_random_declarations();
    int unsigned stop_at;
    int unsigned cut;
    stop_at = sent_items + RANDOM_ITEMS;
    while (sent_items < stop_at) begin
      text_buf.delete();
      repeat ($urandom_range(3, 25)) begin
        put_piece();
        if ($urandom_range(0, 1) == 0) begin
          put_blank();
        end
      end
      cut = text_buf.size();
      if ($urandom_range(0, 5) == 0) begin
        cut = $urandom_range(0, text_buf.size());
      end
      tx_gaps_on = ($urandom_range(0, 3) != 0);
      rx_gaps_on = ($urandom_range(0, 3) != 0);
      for (int i = 0; i < cut; i++) begin
        send_word(text_buf[i], 1'b0);
      end
      end_text();
      if ($urandom_range(0, 7) == 0) begin
        wait_tokens_drained();
      end
    end
    tx_gaps_on = 1'b1;
    rx_gaps_on = 1'b1;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_tokens();
    test_text_end_flush();
    test_body_nesting();
    test_receiver_hold();
    test_random_declarations();
    in_tvalid <= 1'b0;
    while (expected_tokens.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #30_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/dlex_pkg.sv
rtl/core/dlex_front.sv
rtl/core/dlex_queue.sv
rtl/core/declaration_lexer_top.sv
sim/testbench.sv
